// ===== hw/rtl/rau_pkg.sv =====
// Shared types and constants for the rational arithmetic unit.
// No dependencies; used by the controller, the datapath, the top level and the checker.
`default_nettype none

package rau_pkg;

  localparam int OPERAND_WIDTH_DEF = 16;
  localparam int CMD_W             = 2;
  localparam int RES_W             = 33;
  localparam int OUT_TDATA_W       = ((2 * RES_W + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } rau_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B,
    ST_MUL_C,
    ST_COMBINE,
    ST_NORM,
    ST_GCD,
    ST_SCALE,
    ST_DIV,
    ST_WRITE
  } rau_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_A,
    OP_MUL_B,
    OP_MUL_C,
    OP_COMBINE,
    OP_NORM,
    OP_GCD,
    OP_SCALE,
    OP_DIV,
    OP_WRITE
  } rau_op_t;

  typedef struct packed {
    rau_op_t op;
  } rau_ctrl_t;

  typedef struct packed {
    logic reduce;
    logic gcd_done;
    logic div_done;
    logic out_free;
  } rau_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rau_ctrl.sv =====
// Sequencer for the rational arithmetic unit: steps the datapath through
// multiply, combine, normalize, GCD, scaling, division and output write. Depends on rau_pkg.
`default_nettype none

module rau_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire rau_pkg::rau_status_t status,
  output rau_pkg::rau_ctrl_t        ctrl
);
  import rau_pkg::*;

  rau_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl.op    = OP_NONE;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.op    = OP_LOAD;
          state_next = ST_MUL_A;
        end
      end
      ST_MUL_A: begin
        ctrl.op    = OP_MUL_A;
        state_next = ST_MUL_B;
      end
      ST_MUL_B: begin
        ctrl.op    = OP_MUL_B;
        state_next = ST_MUL_C;
      end
      ST_MUL_C: begin
        ctrl.op    = OP_MUL_C;
        state_next = ST_COMBINE;
      end
      ST_COMBINE: begin
        ctrl.op    = OP_COMBINE;
        state_next = ST_NORM;
      end
      ST_NORM: begin
        ctrl.op    = OP_NORM;
        state_next = status.reduce ? ST_GCD : ST_WRITE;
      end
      ST_GCD: begin
        if (status.gcd_done) begin
          state_next = ST_SCALE;
        end else begin
          ctrl.op = OP_GCD;
        end
      end
      ST_SCALE: begin
        ctrl.op    = OP_SCALE;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (status.div_done) begin
          state_next = ST_WRITE;
        end else begin
          ctrl.op = OP_DIV;
        end
      end
      ST_WRITE: begin
        if (status.out_free) begin
          ctrl.op    = OP_WRITE;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rau_datapath.sv =====
// Datapath of the rational arithmetic unit: shared multiplier, normalizer,
// binary GCD, dual restoring divider and output register. Depends on rau_pkg.
`default_nettype none

module rau_datapath #(
  parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire rau_pkg::rau_ctrl_t              ctrl,
  output rau_pkg::rau_status_t                 status,
  input  wire rau_pkg::rau_cmd_t               command,
  input  wire logic signed [OPERAND_WIDTH-1:0] first_num,
  input  wire logic signed [OPERAND_WIDTH-1:0] first_den,
  input  wire logic signed [OPERAND_WIDTH-1:0] second_num,
  input  wire logic signed [OPERAND_WIDTH-1:0] second_den,
  output logic signed [rau_pkg::RES_W-1:0]     result_num,
  output logic signed [rau_pkg::RES_W-1:0]     result_den,
  output logic                                 div_by_zero,
  output logic                                 out_valid,
  input  wire logic                            out_ready
);
  import rau_pkg::*;

  localparam int W  = OPERAND_WIDTH;
  localparam int PW = 2 * W;
  localparam int IW = (2 * W + 1 > 64) ? 64 : 2 * W + 1;
  localparam int CW = $clog2(IW + 1);

  rau_cmd_t            cmd;
  logic signed [W-1:0] n1, d1, n2, d2;
  logic signed [PW-1:0] prod_a, prod_b, prod_c;
  logic signed [IW-1:0] num, den;
  logic                 dz;
  logic [IW-1:0]        ga, gb, g;
  logic [CW-1:0]        k, cnt;
  logic                 neg, reduced;
  logic [IW-1:0]        qn, qd, rn, rd;

  logic signed [W-1:0]  ma, mb;
  logic signed [PW-1:0] mprod;
  logic signed [IW-1:0] a_ext, b_ext, c_ext;
  logic signed [IW-1:0] comb_num, comb_den;
  logic                 comb_dz;
  logic                 flip;
  logic signed [IW-1:0] num_n, den_n;
  logic [IW-1:0]        mag;
  logic [IW-1:0]        tn, td;
  logic signed [IW-1:0] fin_num;

  // shared multiplier operand select
  always_comb begin
    case (ctrl.op)
      OP_MUL_A: begin
        ma = n1;
        mb = (cmd == CMD_MUL) ? n2 : d2;
      end
      OP_MUL_B: begin
        ma = n2;
        mb = d1;
      end
      default: begin
        ma = d1;
        mb = (cmd == CMD_DIV) ? n2 : d2;
      end
    endcase
  end

  assign mprod = PW'(ma) * PW'(mb);

  assign a_ext = IW'(prod_a);
  assign b_ext = IW'(prod_b);
  assign c_ext = IW'(prod_c);

  always_comb begin
    comb_den = c_ext;
    comb_dz  = 1'b0;
    case (cmd)
      CMD_ADD: comb_num = a_ext + b_ext;
      CMD_SUB: comb_num = a_ext - b_ext;
      CMD_MUL: comb_num = a_ext;
      CMD_DIV: begin
        if (n2 == '0) begin
          comb_num = IW'(n1);
          comb_den = IW'(d1);
          comb_dz  = 1'b1;
        end else begin
          comb_num = a_ext;
        end
      end
      default: comb_num = a_ext;
    endcase
  end

  assign flip  = (num != '0) && den[IW-1];
  assign num_n = flip ? -num : num;
  assign den_n = flip ? -den : den;
  assign mag   = num[IW-1] ? IW'(-num) : IW'(num);

  assign status.reduce   = (den_n != '0) && !den_n[IW-1];
  assign status.gcd_done = (ga == '0);
  assign status.div_done = (cnt == CW'(IW));
  assign status.out_free = !out_valid || out_ready;

  assign tn = {rn[IW-2:0], qn[IW-1]};
  assign td = {rd[IW-2:0], qd[IW-1]};

  assign fin_num = neg ? -$signed(qn) : $signed(qn);

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_LOAD: begin
        cmd <= command;
        n1  <= first_num;
        d1  <= first_den;
        n2  <= second_num;
        d2  <= second_den;
      end
      OP_MUL_A: prod_a <= mprod;
      OP_MUL_B: prod_b <= mprod;
      OP_MUL_C: prod_c <= mprod;
      OP_COMBINE: begin
        num <= comb_num;
        den <= comb_den;
        dz  <= comb_dz;
      end
      OP_NORM: begin
        num     <= num_n;
        den     <= den_n;
        neg     <= num_n[IW-1];
        reduced <= status.reduce;
        ga      <= mag;
        gb      <= den_n;
        k       <= '0;
      end
      OP_GCD: begin
        if (ga != '0) begin
          if (!ga[0] && !gb[0]) begin
            ga <= ga >> 1;
            gb <= gb >> 1;
            k  <= k + CW'(1);
          end else if (!ga[0]) begin
            ga <= ga >> 1;
          end else if (!gb[0]) begin
            gb <= gb >> 1;
          end else if (ga >= gb) begin
            ga <= ga - gb;
          end else begin
            ga <= gb - ga;
            gb <= ga;
          end
        end
      end
      OP_SCALE: begin
        g   <= gb << k;
        qn  <= mag;
        qd  <= den;
        rn  <= '0;
        rd  <= '0;
        cnt <= '0;
      end
      OP_DIV: begin
        if (tn >= g) begin
          rn <= tn - g;
          qn <= {qn[IW-2:0], 1'b1};
        end else begin
          rn <= tn;
          qn <= {qn[IW-2:0], 1'b0};
        end
        if (td >= g) begin
          rd <= td - g;
          qd <= {qd[IW-2:0], 1'b1};
        end else begin
          rd <= td;
          qd <= {qd[IW-2:0], 1'b0};
        end
        cnt <= cnt + CW'(1);
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.op == OP_WRITE) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == OP_WRITE) begin
      result_num  <= reduced ? RES_W'(fin_num) : RES_W'(num);
      result_den  <= reduced ? RES_W'($signed(qd)) : RES_W'(den);
      div_by_zero <= dz;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rational_arith_unit_core.sv =====
// Rational arithmetic unit: add, subtract, multiply or divide two signed
// fractions, then normalize the sign and reduce by the GCD.
//
// Input channel s_*: one transaction carries a command (s_tuser) and two
// fractions (s_tdata). Output channel m_*: one transaction per input, the
// reduced numerator and denominator (m_tdata) and a divide-by-zero flag (m_tuser).
// One item is processed at a time; s_tready is high only while the unit is idle.
// After accept the unit forms the three cross products, combines and normalizes
// them, then writes the result when no reduction applies (zero denominator, or
// zero numerator over negative denominator); otherwise it runs the binary GCD,
// one subtract or shift per cycle, then scales the GCD and divides by it on two
// restoring dividers side by side, internal width IW (33 at the default operand width).
// The three cross products share one multiplier, one product per cycle.
// A finished result sits in the output register; the next item is accepted
// while it waits. If the receiver stalls longer, the unit holds its result
// in the write step until the output register frees up.
// Reset clears the sequencer and the output valid; m_tvalid goes low.
// Depends on rau_pkg, rau_ctrl and rau_datapath.
`default_nettype none

module rational_arith_unit_core #(
  parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    s_tvalid,
  output logic                                         s_tready,
  // first_num, first_den, second_num, second_den
  input  wire logic [((4*OPERAND_WIDTH+7)/8)*8-1:0]    s_tdata,
  // command
  input  wire logic [rau_pkg::CMD_W-1:0]               s_tuser,
  output logic                                         m_tvalid,
  input  wire logic                                    m_tready,
  // result_num, result_den
  output logic [rau_pkg::OUT_TDATA_W-1:0]              m_tdata,
  // div_by_zero
  output logic                                         m_tuser
);
  import rau_pkg::*;

  localparam int W = OPERAND_WIDTH;

  rau_ctrl_t             ctrl;
  rau_status_t           status;
  logic signed [RES_W-1:0] result_num, result_den;

  rau_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .ctrl     (ctrl)
  );

  rau_datapath #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .status      (status),
    .command     (rau_cmd_t'(s_tuser)),
    .first_num   (s_tdata[W-1:0]),
    .first_den   (s_tdata[2*W-1:W]),
    .second_num  (s_tdata[3*W-1:2*W]),
    .second_den  (s_tdata[4*W-1:3*W]),
    .result_num  (result_num),
    .result_den  (result_den),
    .div_by_zero (m_tuser),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready)
  );

  assign m_tdata = OUT_TDATA_W'({result_den, result_num});

endmodule

`default_nettype wire

// ===== hw/rtl/rau_checker.sv =====
// Port-level checker for rational_arith_unit_core, attached by bind.
// Depends on rau_pkg.
`default_nettype none

module rau_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             s_tvalid,
  input wire logic                             s_tready,
  input wire logic                             m_tvalid,
  input wire logic                             m_tready,
  input wire logic [rau_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input wire logic                             m_tuser
);

  a_reset_state: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("unit not idle after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second transaction accepted while busy");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
    else $error("result appeared one cycle after accept");

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("m_tvalid dropped while stalled");

  a_data_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("output changed while stalled");

endmodule

bind rational_arith_unit_core rau_checker u_rau_checker (.*);

`default_nettype wire

// ===== bench/tb.sv =====
// Testbench for rational_arith_unit_core: directed and random fraction operations,
// checked against an in-bench predictor of the normalized, GCD-reduced result.
// Depends on rau_pkg and the rational_arith_unit_core RTL.
module tb;
  import rau_pkg::*;

  localparam int OW = OPERAND_WIDTH_DEF;
  localparam int SW = ((4 * OW + 7) / 8) * 8;

  typedef struct {
    logic [RES_W-1:0] num;
    logic [RES_W-1:0] den;
    logic             dbz;
  } ratio_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [SW-1:0]    s_tdata = '0;
  logic [CMD_W-1:0] s_tuser = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic             m_tuser;

  ratio_t pending_ratios[$];
  int     errors = 0;
  int     long_stall_req = 0;
  int     burst_left = 0;

  rational_arith_unit_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
    logic [63:0] t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // full 64-bit cross products, sign normalization, then GCD reduction
  function automatic ratio_t reduce_fraction(rau_cmd_t cmd, logic [OW-1:0] n1_in,
                                             logic [OW-1:0] d1_in, logic [OW-1:0] n2_in,
                                             logic [OW-1:0] d2_in);
    logic [63:0] n1, d1, n2, d2, num, den, g, mag;
    ratio_t r;
    n1 = {{(64-OW){n1_in[OW-1]}}, n1_in};
    d1 = {{(64-OW){d1_in[OW-1]}}, d1_in};
    n2 = {{(64-OW){n2_in[OW-1]}}, n2_in};
    d2 = {{(64-OW){d2_in[OW-1]}}, d2_in};
    r.dbz = 1'b0;
    case (cmd)
      CMD_ADD: begin
        num = n1 * d2 + n2 * d1;
        den = d1 * d2;
      end
      CMD_SUB: begin
        num = n1 * d2 - n2 * d1;
        den = d1 * d2;
      end
      CMD_MUL: begin
        num = n1 * n2;
        den = d1 * d2;
      end
      default: begin
        if (n2 != 0) begin
          num = n1 * d2;
          den = d1 * n2;
        end else begin
          num = n1;
          den = d1;
          r.dbz = 1'b1;
        end
      end
    endcase
    if (num != 0 && den[63]) begin
      num = -num;
      den = -den;
    end
    if (den != 0 && !den[63]) begin
      mag = num[63] ? -num : num;
      g = gcd64(mag, den);
      mag = mag / g;
      num = num[63] ? -mag : mag;
      den = den / g;
    end
    r.num = num[RES_W-1:0];
    r.den = den[RES_W-1:0];
    return r;
  endfunction

  task automatic send_fraction_op(rau_cmd_t cmd, int n1, int d1, int n2, int d2);
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {OW'(d2), OW'(n2), OW'(d1), OW'(n1)};
    do @(posedge clk); while (!s_tready);
    pending_ratios.insert(pending_ratios.size(),
                          reduce_fraction(cmd, OW'(n1), OW'(d1), OW'(n2), OW'(d2)));
  endtask

  // bursts of random length separated by random gaps, some of them long
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 160) : $urandom_range(0, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic wait_for_drain();
    s_tvalid <= 1'b0;
    while (pending_ratios.size() != 0) @(posedge clk);
  endtask

  function automatic int pick_operand();
    int v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: v = -32768;
          1: v = 32767;
          2: v = 0;
          3: v = 1;
          default: v = -1;
        endcase
      end
      1, 2, 3: v = int'($urandom_range(0, 40)) - 20;
      default: v = $urandom_range(0, 65535);
    endcase
    return v;
  endfunction

  task automatic send_random_op();
    rau_cmd_t cmd;
    cmd = rau_cmd_t'($urandom_range(0, 3));
    send_fraction_op(cmd, pick_operand(), pick_operand(), pick_operand(), pick_operand());
  endtask

  task automatic test_directed();
    send_fraction_op(CMD_ADD, 1, 2, 1, 3);
    send_fraction_op(CMD_SUB, 1, 2, 1, 2);
    send_fraction_op(CMD_MUL, 32767, -32768, -32768, 32767);
    send_fraction_op(CMD_DIV, -32768, -32768, -32768, -32768);
    send_fraction_op(CMD_ADD, 32767, 32767, -32768, -32768);
    send_fraction_op(CMD_SUB, -32768, 1, 32767, 1);
    send_fraction_op(CMD_ADD, -32768, 32767, -32768, 32767);
    send_fraction_op(CMD_MUL, 32767, 1, 32767, 1);
    send_fraction_op(CMD_MUL, -1, -1, -1, -1);
    // divide by a zero numerator returns the first operand, normalized and reduced
    send_fraction_op(CMD_DIV, 5, 7, 0, 3);
    send_fraction_op(CMD_DIV, -4, -6, 0, 9);
    send_fraction_op(CMD_DIV, 3, 0, 0, 1);
    send_fraction_op(CMD_DIV, 0, 0, 0, 0);
    // zero denominator passes through
    send_fraction_op(CMD_ADD, 1, 0, 1, 5);
    send_fraction_op(CMD_ADD, 0, 0, 0, 0);
    // zero over negative passes through
    send_fraction_op(CMD_MUL, 0, 1, 3, -2);
    send_fraction_op(CMD_SUB, 0, -1, 0, 1);
    // zero over positive reduces to 0/1
    send_fraction_op(CMD_DIV, 0, 5, 7, -3);
    send_fraction_op(CMD_DIV, 3, 4, -2, 5);
    send_fraction_op(CMD_DIV, 1, 32767, -32768, 1);
    wait_for_drain();
  endtask

  task automatic test_random_ops(int count);
    repeat (count) begin
      send_random_op();
      pace_sender();
    end
    wait_for_drain();
  endtask

  task automatic test_output_backpressure();
    long_stall_req = 400;
    repeat (8) send_random_op();
    wait_for_drain();
  endtask

  task automatic test_drain_pause();
    repeat (4) begin
      repeat ($urandom_range(2, 6)) send_random_op();
      wait_for_drain();
    end
  endtask

  task automatic check_ratio_out();
    ratio_t want;
    if (pending_ratios.size() == 0) begin
      $error("unexpected result transaction: num %0d den %0d",
             $signed(m_tdata[RES_W-1:0]), $signed(m_tdata[2*RES_W-1:RES_W]));
      errors++;
    end else begin
      want = pending_ratios.pop_front();
      if (m_tdata[RES_W-1:0] !== want.num) begin
        $error("result_num mismatch: expected %0d, got %0d",
               $signed(want.num), $signed(m_tdata[RES_W-1:0]));
        errors++;
      end
      if (m_tdata[2*RES_W-1:RES_W] !== want.den) begin
        $error("result_den mismatch: expected %0d, got %0d",
               $signed(want.den), $signed(m_tdata[2*RES_W-1:RES_W]));
        errors++;
      end
      if (m_tuser !== want.dbz) begin
        $error("div_by_zero mismatch: expected %0b, got %0b", want.dbz, m_tuser);
        errors++;
      end
    end
  endtask

  // result side: random stall pattern plus an on-request long hold
  initial begin
    int hold_left;
    int mode;
    int mode_left;
    hold_left = 0;
    mode = 0;
    mode_left = 0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) check_ratio_out();
      if (long_stall_req > 0) begin
        hold_left = long_stall_req;
        long_stall_req = 0;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(10, 80);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);
    test_directed();
    test_output_backpressure();
    test_random_ops(300);
    test_drain_pause();
    test_output_backpressure();
    test_random_ops(260);
    wait_for_drain();
    repeat (200) @(posedge clk);
    if (errors == 0 && pending_ratios.size() == 0) begin
      $display("PASS rational_arith_unit_core");
    end else begin
      $display("FAIL rational_arith_unit_core");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("FAIL rational_arith_unit_core");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/rau_pkg.sv
hw/rtl/rau_ctrl.sv
hw/rtl/rau_datapath.sv
hw/rtl/rational_arith_unit_core.sv
hw/rtl/rau_checker.sv
bench/tb.sv
